### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at each rising edge outside reset
`define LGE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at each rising edge outside reset
`define LGE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/lge_pkg.sv
// types, constants and codes of the life generation engine
`default_nettype none

package lge_pkg;

   // grid size
   localparam int MAX_COLS  = 64;
   localparam int MAX_ROWS  = 64;
   localparam int COL_IDX_W = $clog2(MAX_COLS);
   localparam int ROW_IDX_W = $clog2(MAX_ROWS);
   localparam int COL_CNT_W = COL_IDX_W + 1;
   localparam int ROW_CNT_W = ROW_IDX_W + 1;

   // request and register field widths
   localparam int FUNC_W  = 3;
   localparam int COORD_W = 6;
   localparam int CFG_W   = 7;
   localparam int CSR_IDX_W = 1;
   localparam int NBR_W   = 4;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_TOGGLE = 3'd1;
   localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
   localparam logic [FUNC_W-1:0] FN_STEP   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b1;

   // life rule neighbour counts
   localparam logic [NBR_W-1:0] SURVIVE_MIN = 4'd2;
   localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;

   typedef logic [MAX_COLS-1:0] row_type;

   // request held for the length of a pass
   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [COL_IDX_W-1:0] col;
      logic [ROW_IDX_W-1:0] row;
      logic                 new_value;
      logic                 in_range;
   } req_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PASS = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/lge_req_if.sv
// request channel of the life generation engine
`default_nettype none

interface lge_req_if;
   logic                          valid;
   logic                          ready;
   logic [lge_pkg::FUNC_W-1:0]    func;
   logic [lge_pkg::COORD_W-1:0]   col;
   logic [lge_pkg::COORD_W-1:0]   row;
   logic                          new_value;

   modport source (output valid, func, col, row, new_value, input ready);
   modport sink (input valid, func, col, row, new_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/lge_rsp_if.sv
// response channel of the life generation engine
`default_nettype none

interface lge_rsp_if;
   logic valid;
   logic ready;
   logic alive;
   logic status;

   modport source (output valid, alive, status, input ready);
   modport sink (input valid, alive, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/lge_row_cell.sv
// one row of the grid, a link in the rotating chain of rows
`default_nettype none

module lge_row_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  lge_pkg::row_type shift_data,
   output lge_pkg::row_type row_out
);
   import lge_pkg::*;

   row_type bits_ff;
   row_type bits_in;

   // take the neighbour's row while the chain turns
   always_comb begin
      bits_in = shift_en ? shift_data : bits_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

   assign row_out = bits_ff;

endmodule

`default_nettype wire

### hw/rtl/lge_row_unit.sv
// new value of the row at the head of the chain: life rule, edits and clear
`default_nettype none

module lge_row_unit (
   input  lge_pkg::req_type                   req,
   input  logic [lge_pkg::ROW_IDX_W-1:0]      pass_idx,
   input  logic [lge_pkg::ROW_CNT_W-1:0]      rows_used,
   input  lge_pkg::row_type                   col_mask,
   input  lge_pkg::row_type                   above,
   input  lge_pkg::row_type                   head,
   input  lge_pkg::row_type                   below,
   output lge_pkg::row_type                   next_row,
   output logic                               alive
);
   import lge_pkg::*;

   logic                  hit;
   logic                  is_access;
   logic [ROW_CNT_W-1:0]  idx_ext;
   row_type               col_bit;
   row_type               below_m;
   row_type               life_row;
   logic [MAX_COLS+1:0]   a_x;
   logic [MAX_COLS+1:0]   c_x;
   logic [MAX_COLS+1:0]   b_x;
   logic [NBR_W-1:0]      nbr;

   // neighbourhood of the head row, dead outside the used area
   always_comb begin
      idx_ext = {1'b0, pass_idx};
      below_m = ((idx_ext + ROW_CNT_W'(1)) < rows_used) ? (below & col_mask) : '0;
      a_x     = {1'b0, above, 1'b0};
      c_x     = {1'b0, head & col_mask, 1'b0};
      b_x     = {1'b0, below_m, 1'b0};
      nbr     = '0;
      life_row = '0;
      for (int c = 0; c < MAX_COLS; c++) begin
         nbr = NBR_W'(a_x[c]) + NBR_W'(a_x[c+1]) + NBR_W'(a_x[c+2])
             + NBR_W'(c_x[c]) + NBR_W'(c_x[c+2])
             + NBR_W'(b_x[c]) + NBR_W'(b_x[c+1]) + NBR_W'(b_x[c+2]);
         life_row[c] = c_x[c+1] ? (nbr == SURVIVE_MIN || nbr == BIRTH_COUNT)
                                : (nbr == BIRTH_COUNT);
      end
      life_row = life_row & col_mask;
      if (idx_ext >= rows_used) begin
         life_row = '0;
      end
   end

   // operation on the head row
   always_comb begin
      hit       = req.in_range && (pass_idx == req.row);
      is_access = (req.func == FN_WRITE) || (req.func == FN_TOGGLE) ||
                  (req.func == FN_READ);
      col_bit   = row_type'(1) << req.col;
      next_row  = head;
      case (req.func)
         FN_WRITE: begin
            if (hit) begin
               next_row = req.new_value ? (head | col_bit) : (head & ~col_bit);
            end
         end
         FN_TOGGLE: begin
            if (hit) begin
               next_row = head ^ col_bit;
            end
         end
         FN_READ:  next_row = head;
         FN_STEP:  next_row = life_row;
         FN_CLEAR: next_row = '0;
         default:  next_row = head;
      endcase
      alive = hit && is_access && next_row[req.col];
   end

endmodule

`default_nettype wire

### hw/rtl/life_generation_engine_unit.sv
// top level of the life generation engine: row chain, control and channels
// Usage:
//  - req_chan carries one request: func (write, toggle, read, advance a
//    generation, clear), col, row and new_value; taken when valid and ready.
//  - rsp_chan returns one response per request, in order: alive and status.
//  - csr_we / csr_index / csr_wdata set the columns (index 0) and rows
//    (index 1) in use; write only while no request is outstanding.
//  - The grid is a ring of MAX_ROWS row registers. Every request turns the
//    ring once, one row per cycle, past the single row unit at its head.
//  - The response enters the output register when the pass ends and the
//    output slot is free; no new request is taken while the ring turns.
//  - req_chan.ready is high only when idle, not while turning or holding a
//    result; a new request may be taken while the previous response is
//    still waiting in the output register. If that response is still not
//    taken when the next pass ends, the result is held and the block waits.
//  - Reset (synchronous, active high) kills every cell, sets both sizes to
//    64 and empties the output register.
`default_nettype none
`include "assert_macros.svh"

module life_generation_engine_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lge_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lge_pkg::CFG_W-1:0]            csr_wdata,
   lge_req_if.sink                              req_chan,
   lge_rsp_if.source                            rsp_chan
);
   import lge_pkg::*;

   localparam logic [ROW_IDX_W-1:0] LAST_IDX = ROW_IDX_W'(MAX_ROWS - 1);

   // configuration
   logic [CFG_W-1:0]     cols_ff, cols_in;
   logic [CFG_W-1:0]     rows_ff, rows_in;
   logic [COL_CNT_W-1:0] cols_used;
   logic [ROW_CNT_W-1:0] rows_used;
   row_type              col_mask;

   // control
   state_type            state_ff, state_in;
   logic [ROW_IDX_W-1:0] idx_ff, idx_in;
   req_type              req_ff, req_in;
   logic                 status_ff, status_in;
   logic                 alive_ff, alive_in;
   row_type              above_ff, above_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_alive_ff, rsp_alive_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                 accept;
   logic                 slot_free;
   logic                 load_rsp;
   logic                 shift_en;
   logic                 in_range;
   logic                 is_access;
   logic                 unit_alive;
   row_type              unit_row;
   row_type              chain [MAX_ROWS];

   // register writes
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COLS: cols_in = csr_wdata;
            CSR_ROWS: rows_in = csr_wdata;
            default:  cols_in = cols_ff;
         endcase
      end
   end

   // sizes clamped to the grid, and the used-column mask
   always_comb begin
      if (cols_ff == '0) begin
         cols_used = COL_CNT_W'(1);
      end else if (COL_CNT_W'(cols_ff) > COL_CNT_W'(MAX_COLS)) begin
         cols_used = COL_CNT_W'(MAX_COLS);
      end else begin
         cols_used = COL_CNT_W'(cols_ff);
      end
      if (rows_ff == '0) begin
         rows_used = ROW_CNT_W'(1);
      end else if (ROW_CNT_W'(rows_ff) > ROW_CNT_W'(MAX_ROWS)) begin
         rows_used = ROW_CNT_W'(MAX_ROWS);
      end else begin
         rows_used = ROW_CNT_W'(rows_ff);
      end
      for (int c = 0; c < MAX_COLS; c++) begin
         col_mask[c] = COL_CNT_W'(c) < cols_used;
      end
   end

   // request decode at the accepting edge
   always_comb begin
      accept    = req_chan.valid && req_chan.ready;
      is_access = (req_chan.func == FN_WRITE) || (req_chan.func == FN_TOGGLE) ||
                  (req_chan.func == FN_READ);
      in_range  = (COL_CNT_W'(req_chan.col) < cols_used) &&
                  (ROW_CNT_W'(req_chan.row) < rows_used);
   end

   // sequencer: rest, one full turn of the ring, wait for the output slot
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      req_in        = req_ff;
      status_in     = status_ff;
      alive_in      = alive_ff;
      above_in      = above_ff;
      load_rsp      = 1'b0;
      shift_en      = 1'b0;
      slot_free     = !rsp_valid_ff || rsp_chan.ready;
      rsp_alive_in  = rsp_alive_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in.func      = req_chan.func;
               req_in.col       = COL_IDX_W'(req_chan.col);
               req_in.row       = ROW_IDX_W'(req_chan.row);
               req_in.new_value = req_chan.new_value;
               req_in.in_range  = is_access && in_range;
               status_in        = is_access && !in_range;
               alive_in         = 1'b0;
               above_in         = '0;
               idx_in           = '0;
               state_in         = ST_PASS;
            end
         end
         ST_PASS: begin
            shift_en = 1'b1;
            above_in = chain[0] & col_mask;
            alive_in = alive_ff | unit_alive;
            idx_in   = idx_ff + ROW_IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               if (slot_free) begin
                  load_rsp      = 1'b1;
                  rsp_alive_in  = alive_ff | unit_alive;
                  rsp_status_in = status_ff;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               load_rsp      = 1'b1;
               rsp_alive_in  = alive_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         cols_ff      <= CFG_W'(MAX_COLS);
         rows_ff      <= CFG_W'(MAX_ROWS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request, scratch and response payload
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      status_ff     <= status_in;
      alive_ff      <= alive_in;
      above_ff      <= above_in;
      rsp_alive_ff  <= rsp_alive_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ring of row cells, the head feeds the row unit, its result enters the tail
   for (genvar i = 0; i < MAX_ROWS; i++) begin : g_ring
      lge_row_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .shift_data ((i == MAX_ROWS - 1) ? unit_row : chain[(i + 1) % MAX_ROWS]),
         .row_out    (chain[i])
      );
   end

   lge_row_unit u_unit (
      .req       (req_ff),
      .pass_idx  (idx_ff),
      .rows_used (rows_used),
      .col_mask  (col_mask),
      .above     (above_ff),
      .head      (chain[0]),
      .below     (chain[1]),
      .next_row  (unit_row),
      .alive     (unit_alive)
   );

   // channel outputs
   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.alive  = rsp_alive_ff;
   assign rsp_chan.status = rsp_status_ff;

   // checks
   `LGE_ASSERT_NEXT(a_accept_starts_pass, clock, reset, accept,
      (state_ff == ST_PASS) && (idx_ff == '0),
      "accepted request did not start a pass at the head row")
   `LGE_ASSERT_NEXT(a_pass_ends, clock, reset,
      (state_ff == ST_PASS) && (idx_ff == LAST_IDX), state_ff != ST_PASS,
      "ring turned more than once for a request")
   `LGE_ASSERT_NOW(a_hold_needs_busy_slot, clock, reset, state_ff == ST_HOLD,
      rsp_valid_ff, "result held while the output slot is empty")
   `LGE_ASSERT_NOW(a_ignored_is_dead, clock, reset, rsp_valid_ff,
      !(rsp_alive_ff && rsp_status_ff), "ignored access answered a live cell")

endmodule

`default_nettype wire

### verif/tb_life_generation_engine_unit.sv
// self-checking testbench of the life generation engine: grid edits, generations and sizes
module tb_life_generation_engine_unit;
   import lge_pkg::*;

   localparam int LATENCY      = MAX_ROWS + 2;
   localparam int TIMEOUT_TIME = 8 * 1000000;
   localparam int LONG_HOLD    = 400;

   // codes the block does not use
   localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = FN_CLEAR + FUNC_W'(1);
   localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = '1;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               new_value;
      bit                 drain_first;
   } cell_req_type;

   typedef struct {
      logic alive;
      logic status;
   } cell_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   lge_req_if req_if ();
   lge_rsp_if rsp_if ();

   life_generation_engine_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   // predicted grid and register copies
   row_type life_grid [MAX_ROWS];
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;

   cell_req_type pending_reqs [$];
   cell_result_type expected_cells [$];
   cell_req_type staged_req;

   bit quiet_mode;
   bit drain_next;
   int send_gap;
   int hold_left;
   int requests_accepted;
   int responses_checked;
   int fail_count;
   int generations_run;
   int live_reads;
   int ignored_accesses;
   int sizes_tried;

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // run limit
   initial begin
      #(TIMEOUT_TIME);
      $display("Regression FAIL");
      $finish;
   end

   // effective grid size after clamping the registers
   function automatic int grid_width();
      int w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAX_COLS) w = MAX_COLS;
      return w;
   endfunction

   function automatic int grid_height();
      int h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > MAX_ROWS) h = MAX_ROWS;
      return h;
   endfunction

   function automatic int live_at(row_type w, int pos);
      if (pos < 0 || pos >= MAX_COLS) return 0;
      return int'(w[pos]);
   endfunction

   // one generation, walked row by row with the old row above kept aside
   function automatic void step_generation();
      int w, h, n;
      row_type mask, above, cur, below, nxt;
      w = grid_width();
      h = grid_height();
      mask = (w >= MAX_COLS) ? '1 : ((row_type'(1) << w) - row_type'(1));
      above = '0;
      for (int r = 0; r < MAX_ROWS; r++) begin
         if (r >= h) begin
            life_grid[r] = '0;
         end else begin
            cur = life_grid[r] & mask;
            below = (r + 1 < h) ? (life_grid[r + 1] & mask) : '0;
            nxt = '0;
            for (int c = 0; c < w; c++) begin
               n = live_at(above, c - 1) + live_at(above, c) + live_at(above, c + 1)
                 + live_at(cur, c - 1) + live_at(cur, c + 1)
                 + live_at(below, c - 1) + live_at(below, c) + live_at(below, c + 1);
               if (cur[c]) nxt[c] = (n == SURVIVE_MIN || n == BIRTH_COUNT);
               else nxt[c] = (n == BIRTH_COUNT);
            end
            above = cur;
            life_grid[r] = nxt;
         end
      end
   endfunction

   // apply an accepted request to the grid copy and queue its response
   function automatic void apply_request(cell_req_type q);
      cell_result_type res;
      res.alive = 1'b0;
      res.status = 1'b0;
      case (q.func)
         FN_WRITE, FN_TOGGLE, FN_READ: begin
            if (q.col >= grid_width() || q.row >= grid_height()) begin
               res.status = 1'b1;
               ignored_accesses++;
            end else begin
               if (q.func == FN_WRITE) life_grid[q.row][q.col] = q.new_value;
               else if (q.func == FN_TOGGLE) life_grid[q.row][q.col] = ~life_grid[q.row][q.col];
               res.alive = life_grid[q.row][q.col];
               if (q.func == FN_READ && res.alive) live_reads++;
            end
         end
         FN_STEP: begin
            step_generation();
            generations_run++;
         end
         FN_CLEAR: begin
            foreach (life_grid[r]) life_grid[r] = '0;
         end
         default: ;
      endcase
      expected_cells.push_back(res);
   endfunction

   function automatic void queue_op(logic [FUNC_W-1:0] f, int c, int r, bit v);
      cell_req_type q;
      q.func = f;
      q.col = COORD_W'(c);
      q.row = COORD_W'(r);
      q.new_value = v;
      q.drain_first = drain_next;
      drain_next = 1'b0;
      pending_reqs.push_back(q);
   endfunction

   function automatic logic [FUNC_W-1:0] FN_FUNC_SPARE();
      return FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
   endfunction

   // a single request of any kind, in or out of the grid
   function automatic void queue_random_op();
      int pick, c, r;
      logic [FUNC_W-1:0] f;
      pick = $urandom_range(0, 99);
      c = $urandom_range(0, grid_width() - 1);
      r = $urandom_range(0, grid_height() - 1);
      if (pick < 22) f = FN_WRITE;
      else if (pick < 40) f = FN_TOGGLE;
      else if (pick < 62) f = FN_READ;
      else if (pick < 72) f = FN_STEP;
      else if (pick < 75) f = FN_CLEAR;
      else if (pick < 81) f = FN_FUNC_SPARE();
      else begin
         // access beyond the used grid, where the grid is below its maximum size
         f = FUNC_W'($urandom_range(FN_WRITE, FN_READ));
         if (grid_width() < MAX_COLS && ($urandom_range(0, 1) || grid_height() == MAX_ROWS)) begin
            c = $urandom_range(grid_width(), MAX_COLS - 1);
            r = $urandom_range(0, MAX_ROWS - 1);
         end else if (grid_height() < MAX_ROWS) begin
            c = $urandom_range(0, MAX_COLS - 1);
            r = $urandom_range(grid_height(), MAX_ROWS - 1);
         end
      end
      if (f == FN_STEP || f == FN_CLEAR || f >= FN_SPARE_FIRST) begin
         c = $urandom_range(0, MAX_COLS - 1);
         r = $urandom_range(0, MAX_ROWS - 1);
      end
      queue_op(f, c, r, $urandom_range(0, 1));
   endfunction

   // seed a small cluster, run a few generations, read around it
   function automatic int queue_pattern();
      int w, h, bc, br, seeds, gens, reads;
      w = grid_width();
      h = grid_height();
      bc = $urandom_range(0, w - 1);
      br = $urandom_range(0, h - 1);
      seeds = $urandom_range(3, 10);
      gens = $urandom_range(1, 3);
      reads = $urandom_range(3, 8);
      for (int i = 0; i < seeds; i++)
         queue_op(($urandom_range(0, 3) == 0) ? FN_TOGGLE : FN_WRITE,
                  (bc + $urandom_range(0, 3)) % w, (br + $urandom_range(0, 3)) % h,
                  $urandom_range(0, 4) != 0);
      for (int i = 0; i < gens; i++)
         queue_op(FN_STEP, $urandom_range(0, MAX_COLS - 1), $urandom_range(0, MAX_ROWS - 1),
                  $urandom_range(0, 1));
      for (int i = 0; i < reads; i++)
         queue_op(FN_READ, (bc + w - 1 + $urandom_range(0, 5)) % w,
                  (br + h - 1 + $urandom_range(0, 5)) % h, $urandom_range(0, 1));
      return seeds + gens + reads;
   endfunction

   task automatic random_phase(input int n_items);
      int made;
      bit paused;
      made = 0;
      paused = 1'b0;
      while (made < n_items) begin
         // one request halfway through waits for the block to run dry
         if (!paused && made >= n_items / 2) begin
            drain_next = 1'b1;
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 45) made += queue_pattern();
         else begin
            queue_random_op();
            made++;
         end
      end
   endtask

   task automatic wait_for_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || expected_cells.size() != 0 || req_if.valid);
      repeat (4) @(posedge clock);
   endtask

   // resize the grid once nothing is outstanding
   task automatic set_grid_size(input int cols_val, input int rows_val);
      wait_for_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_COLS;
      csr_wdata <= CFG_W'(cols_val);
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= CFG_W'(rows_val);
      @(posedge clock);
      csr_we <= 1'b0;
      width_reg = CFG_W'(cols_val);
      height_reg = CFG_W'(rows_val);
      sizes_tried++;
      @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : driver
      bit offering;
      offering = req_if.valid;
      if (reset) begin
         offering = 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            apply_request(staged_req);
            requests_accepted++;
            offering = 1'b0;
            send_gap = quiet_mode ? 0 : $urandom_range(0, 4);
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain_first && expected_cells.size() > 0)) begin
               staged_req = pending_reqs.pop_front();
               offering = 1'b1;
            end
         end
      end
      req_if.valid <= offering;
      req_if.func <= staged_req.func;
      req_if.col <= staged_req.col;
      req_if.row <= staged_req.row;
      req_if.new_value <= staged_req.new_value;
   end

   // response monitor and checker
   always @(posedge clock) begin : monitor
      cell_result_type want;
      if (reset) begin
         hold_left = 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         if (expected_cells.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = expected_cells.pop_front();
            if (rsp_if.alive !== want.alive) begin
               $error("alive: expected %0b, got %0b", want.alive, rsp_if.alive);
               fail_count++;
            end
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0b, got %0b", want.status, rsp_if.status);
               fail_count++;
            end
         end
         responses_checked++;
         hold_left = quiet_mode ? 0 : $urandom_range(0, 4);
         // long hold-off so the block backs up and stalls its input
         if (responses_checked == 300 || responses_checked == 1200) hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left--;
      end
      rsp_if.ready <= !reset && hold_left == 0;
   end

   // stimulus
   initial begin : stimulus
      int w, h;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_COLS;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.func = FN_READ;
      req_if.col = '0;
      req_if.row = '0;
      req_if.new_value = 1'b0;
      rsp_if.ready = 1'b0;
      staged_req = '{FN_READ, '0, '0, 1'b0, 1'b0};
      foreach (life_grid[r]) life_grid[r] = '0;
      width_reg = CFG_W'(MAX_COLS);
      height_reg = CFG_W'(MAX_ROWS);
      quiet_mode = 1'b0;
      drain_next = 1'b0;
      sizes_tried = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // full grid: corners, toggles, spare codes, clear, an L that grows into a block
      queue_op(FN_WRITE, 0, 0, 1);
      queue_op(FN_READ, 0, 0, 0);
      queue_op(FN_WRITE, MAX_COLS - 1, MAX_ROWS - 1, 1);
      queue_op(FN_READ, MAX_COLS - 1, MAX_ROWS - 1, 0);
      queue_op(FN_TOGGLE, MAX_COLS - 1, 0, 0);
      queue_op(FN_TOGGLE, MAX_COLS - 1, 0, 1);
      queue_op(FN_WRITE, 0, 0, 0);
      queue_op(FN_SPARE_FIRST, MAX_COLS - 1, MAX_ROWS - 1, 1);
      queue_op(FN_SPARE_FIRST + FUNC_W'(1), 0, 0, 0);
      queue_op(FN_SPARE_LAST, 21, 42, 1);
      queue_op(FN_CLEAR, 0, 0, 0);
      queue_op(FN_READ, MAX_COLS - 1, MAX_ROWS - 1, 0);
      queue_op(FN_WRITE, 0, 0, 1);
      queue_op(FN_WRITE, 1, 0, 1);
      queue_op(FN_WRITE, 0, 1, 1);
      queue_op(FN_WRITE, MAX_COLS - 1, MAX_ROWS - 1, 1);
      queue_op(FN_STEP, 0, 0, 0);
      queue_op(FN_READ, 1, 1, 0);
      queue_op(FN_READ, MAX_COLS - 1, MAX_ROWS - 1, 0);
      queue_op(FN_READ, MAX_COLS - 1, 0, 0);

      // 3x3 grid: stored cells survive the resize, outside accesses are refused
      set_grid_size(3, 3);
      queue_op(FN_READ, 3, 0, 0);
      queue_op(FN_WRITE, 0, 3, 1);
      queue_op(FN_TOGGLE, MAX_COLS - 1, MAX_ROWS - 1, 1);
      queue_op(FN_READ, 1, 1, 0);
      queue_op(FN_STEP, MAX_COLS - 1, MAX_ROWS - 1, 1);
      queue_op(FN_READ, 0, 0, 0);
      random_phase(150);

      // registers below and above range clamp to one and the maximum
      set_grid_size(0, 127);
      quiet_mode = 1'b1;
      random_phase(120);
      set_grid_size(127, 0);
      quiet_mode = 1'b0;
      random_phase(120);
      set_grid_size(MAX_COLS, MAX_ROWS);
      random_phase(400);
      set_grid_size(8, 8);
      random_phase(300);
      set_grid_size(65, 100);
      random_phase(200);
      set_grid_size(1, 1);
      random_phase(80);
      for (int i = 0; i < 4; i++) begin
         w = $urandom_range(2, MAX_COLS);
         h = $urandom_range(2, MAX_ROWS);
         set_grid_size(w, h);
         quiet_mode = (i == 2);
         random_phase(120);
      end

      wait_for_idle();
      repeat (LATENCY) @(posedge clock);
      if (expected_cells.size() != 0) begin
         $error("%0d responses never arrived", expected_cells.size());
         fail_count++;
      end
      $display("%0d requests over %0d grid sizes: %0d generations, %0d ignored accesses",
               requests_accepted, sizes_tried, generations_run, ignored_accesses);
      $display("%0d responses checked, %0d live cells read back, %0d mismatches",
               responses_checked, live_reads, fail_count);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/lge_pkg.sv
hw/rtl/lge_req_if.sv
hw/rtl/lge_rsp_if.sv
hw/rtl/lge_row_cell.sv
hw/rtl/lge_row_unit.sv
hw/rtl/life_generation_engine_unit.sv
verif/tb_life_generation_engine_unit.sv
